// ----- rtl/dfrm_pkg.sv -----
// ----------------------------------------------------------------------------
// dfrm_pkg
// Shared types, event codes and marker tables for the length-prefixed
// frame deframer.
// ----------------------------------------------------------------------------
package dfrm_pkg;

	// default payload buffer size, bytes
	localparam int BUFFER_BYTES_DEF = 4096;
	// extra room for header and end marker
	localparam int FRAME_MARGIN = 64;
	localparam int MARK_LEN = 5;

	typedef logic [7:0]  byte_t;
	typedef logic [3:0]  event_t;
	typedef logic [11:0] pay_index_t;
	typedef logic [12:0] frame_len_t;
	typedef logic [1:0]  reg_index_t;

	// event codes
	localparam event_t EV_BUSY       = 4'd0;
	localparam event_t EV_START      = 4'd1;
	localparam event_t EV_RESYNC     = 4'd2;
	localparam event_t EV_STRAY      = 4'd3;
	localparam event_t EV_BAD_START  = 4'd4;
	localparam event_t EV_BAD_LENGTH = 4'd5;
	localparam event_t EV_BAD_END    = 4'd6;
	localparam event_t EV_OVERRUN    = 4'd7;
	localparam event_t EV_DONE       = 4'd8;

	// configuration register indexes
	localparam reg_index_t REG_CODE_A = 2'd0;
	localparam reg_index_t REG_CODE_B = 2'd1;
	localparam reg_index_t REG_CODE_C = 2'd2;

	// ascii characters used by the header
	localparam byte_t CHR_GT   = 8'h3e;
	localparam byte_t CHR_ZERO = 8'h30;
	localparam byte_t CHR_NINE = 8'h39;

	typedef struct packed {
		byte_t code_a;
		byte_t code_b;
		byte_t code_c;
	} chan_codes_t;

	typedef struct packed {
		event_t     event_res;
		logic       payload_valid;
		byte_t      payload_byte;
		pay_index_t payload_index;
		byte_t      channel;
		frame_len_t frame_length;
	} result_t;

	// "<STX=" by position
	function automatic byte_t start_mark(input logic [2:0] pos);
		byte_t c;
		case (pos)
			3'd0:    c = 8'h3c;
			3'd1:    c = 8'h53;
			3'd2:    c = 8'h54;
			3'd3:    c = 8'h58;
			3'd4:    c = 8'h3d;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// "<ETX>" by position
	function automatic byte_t end_mark(input logic [2:0] pos);
		byte_t c;
		case (pos)
			3'd0:    c = 8'h3c;
			3'd1:    c = 8'h45;
			3'd2:    c = 8'h54;
			3'd3:    c = 8'h58;
			3'd4:    c = 8'h3e;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ----- rtl/dfrm_byte_if.sv -----
// ----------------------------------------------------------------------------
// dfrm_byte_if
// Received byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfrm_byte_if;
	import dfrm_pkg::*;

	logic  valid;
	logic  ready;
	byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/dfrm_res_if.sv -----
// ----------------------------------------------------------------------------
// dfrm_res_if
// Parser result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfrm_res_if;
	import dfrm_pkg::*;

	logic       valid;
	logic       ready;
	event_t     event_res;
	logic       payload_valid;
	byte_t      payload_byte;
	pay_index_t payload_index;
	byte_t      channel;
	frame_len_t frame_length;

	modport source (
		output valid, output event_res, output payload_valid, output payload_byte,
		output payload_index, output channel, output frame_length, input ready
	);
	modport sink (
		input valid, input event_res, input payload_valid, input payload_byte,
		input payload_index, input channel, input frame_length, output ready
	);
endinterface

// ----- rtl/dfrm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// dfrm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dfrm_cfg_if;
	import dfrm_pkg::*;

	logic       valid;
	logic       ready;
	reg_index_t index;
	byte_t      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/length_prefixed_frame_deframer.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Parses channel byte, "<STX=" decimal length ">", payload, "<ETX>" frames
// from a byte stream, one result word per received word.
//
//   channel  dir  words carried
//   rx       in   one received byte
//   res      out  event code, payload byte and index, channel, frame length
//   cfg      in   channel code register writes (index, data), always ready
//
// One word a cycle sustained while res is ready; after rx acceptance the word
// sits in the input register, and the parsing step fills the result register,
// which drives res valid. Frame state advances only when a word leaves the
// input register.
// arst_n clears frame state and channel codes; no clearing pass is needed.
// A stall on res backs up through the result and input registers to rx.ready.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer #(
	parameter int BUFFER_BYTES = dfrm_pkg::BUFFER_BYTES_DEF
) (
	input logic  clk,
	input logic  arst_n,
	dfrm_byte_if.sink rx,
	dfrm_res_if.source res,
	dfrm_cfg_if.sink cfg
);
	import dfrm_pkg::*;

	logic        valid_s1;
	byte_t       byte_s1;
	logic        valid_s2;
	result_t     result_s2;
	result_t     step_result;
	chan_codes_t codes;
	logic        adv_s2;
	logic        ready_s1;

	// handshake flow
	assign adv_s2 = valid_s1 && (!valid_s2 || res.ready);
	assign ready_s1 = !valid_s1 || adv_s2;
	assign rx.ready = ready_s1;
	assign cfg.ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	dfrm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_index(cfg.index),
		.wr_data (cfg.data),
		.codes   (codes)
	);

	dfrm_parser #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s2),
		.rx_byte(byte_s1),
		.codes  (codes),
		.result (step_result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2 <= step_result;
		end
	end

	assign res.valid = valid_s2;
	assign res.event_res = result_s2.event_res;
	assign res.payload_valid = result_s2.payload_valid;
	assign res.payload_byte = result_s2.payload_byte;
	assign res.payload_index = result_s2.payload_index;
	assign res.channel = result_s2.channel;
	assign res.frame_length = result_s2.frame_length;
endmodule

// ----- rtl/dfrm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// dfrm_cfg_regs
// Channel code registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module dfrm_cfg_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  dfrm_pkg::reg_index_t wr_index,
	input  dfrm_pkg::byte_t      wr_data,
	output dfrm_pkg::chan_codes_t codes
);
	import dfrm_pkg::*;

	chan_codes_t codes_q;

	// register write decode, unused index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_CODE_A: codes_q.code_a <= wr_data;
				REG_CODE_B: codes_q.code_b <= wr_data;
				REG_CODE_C: codes_q.code_c <= wr_data;
				default: ;
			endcase
		end
	end

	assign codes = codes_q;
endmodule

// ----- rtl/dfrm_parser.sv -----
// ----------------------------------------------------------------------------
// dfrm_parser
// Frame state and the per-byte parsing step: header check, length
// accumulation, payload streaming and end marker check.
// ----------------------------------------------------------------------------
module dfrm_parser #(
	parameter int BUFFER_BYTES = dfrm_pkg::BUFFER_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  dfrm_pkg::byte_t       rx_byte,
	input  dfrm_pkg::chan_codes_t codes,
	output dfrm_pkg::result_t     result
);
	import dfrm_pkg::*;

	localparam int FRAME_CAP = BUFFER_BYTES + FRAME_MARGIN;
	localparam int CW = $clog2(FRAME_CAP + 1);
	localparam int AW = CW + 4;
	localparam int SW = CW + 2;
	localparam logic [CW-1:0] CAP = CW'(FRAME_CAP);
	localparam logic [CW-1:0] MARK = CW'(MARK_LEN);

	// frame state
	logic          in_frame_q, in_frame_d;
	byte_t         frame_channel_q, frame_channel_d;
	logic [CW-1:0] byte_count_q, byte_count_d;
	logic          prefix_matches_q, prefix_matches_d;
	logic          header_done_q, header_done_d;
	logic          seen_digit_q, seen_digit_d;
	logic [CW-1:0] declared_length_q, declared_length_d;
	logic [CW-1:0] payload_start_q, payload_start_d;
	logic          end_marker_ok_q, end_marker_ok_d;

	logic          is_chan;
	logic          resync;
	logic          do_open;
	logic          open_active;
	byte_t         open_chan;
	logic [CW-1:0] cnt_inc;
	logic [SW-1:0] total_len;
	logic [AW-1:0] acc;
	logic [CW-1:0] rel;
	logic [CW-1:0] rel_end;
	logic          em_ok;
	result_t       res;

	assign is_chan = (rx_byte == codes.code_a) || (rx_byte == codes.code_b) ||
		(rx_byte == codes.code_c);
	assign cnt_inc = byte_count_q + 1'b1;
	// header bytes so far plus payload plus end marker
	assign total_len = SW'(cnt_inc) + SW'(declared_length_q) + SW'(MARK);
	// decimal accumulate, times ten as two shifted adds
	assign acc = (AW'(declared_length_q) << 3) + (AW'(declared_length_q) << 1) +
		AW'(rx_byte - CHR_ZERO);
	assign rel = byte_count_q - payload_start_q;
	assign rel_end = rel - declared_length_q;
	assign em_ok = end_marker_ok_q && !((rel_end < MARK) &&
		(rx_byte != end_mark(rel_end[2:0])));

	// restart while the start marker or its length field is still open
	always_comb begin
		if (byte_count_q == '0 || byte_count_q >= MARK) begin
			resync = 1'b1;
		end else begin
			resync = !(prefix_matches_q && rx_byte == start_mark(byte_count_q[2:0]));
		end
	end

	// one parsing step
	always_comb begin
		res = '0;
		res.event_res = EV_BUSY;
		do_open = 1'b0;
		open_active = 1'b0;
		open_chan = '0;
		in_frame_d = in_frame_q;
		frame_channel_d = frame_channel_q;
		byte_count_d = byte_count_q;
		prefix_matches_d = prefix_matches_q;
		header_done_d = header_done_q;
		seen_digit_d = seen_digit_q;
		declared_length_d = declared_length_q;
		payload_start_d = payload_start_q;
		end_marker_ok_d = end_marker_ok_q;

		if (!in_frame_q) begin
			if (!is_chan) begin
				res.event_res = EV_STRAY;
			end else begin
				do_open = 1'b1;
				open_active = 1'b1;
				open_chan = rx_byte;
				res.event_res = EV_START;
			end
		end else if (is_chan && !header_done_q && resync) begin
			do_open = 1'b1;
			open_active = 1'b1;
			open_chan = rx_byte;
			res.event_res = EV_RESYNC;
		end else if (byte_count_q >= CAP) begin
			do_open = 1'b1;
			res.event_res = EV_OVERRUN;
		end else begin
			byte_count_d = cnt_inc;
			if (byte_count_q < MARK) begin
				// start marker
				prefix_matches_d = prefix_matches_q &&
					(rx_byte == start_mark(byte_count_q[2:0]));
				if (cnt_inc == MARK && !prefix_matches_d) begin
					do_open = 1'b1;
					res.event_res = EV_BAD_START;
				end
			end else if (!header_done_q) begin
				// length field
				if (rx_byte == CHR_GT) begin
					if (!seen_digit_q || total_len > SW'(CAP)) begin
						do_open = 1'b1;
						res.event_res = EV_BAD_LENGTH;
					end else begin
						header_done_d = 1'b1;
						payload_start_d = cnt_inc;
					end
				end else if (rx_byte < CHR_ZERO || rx_byte > CHR_NINE) begin
					do_open = 1'b1;
					res.event_res = EV_BAD_LENGTH;
				end else begin
					declared_length_d = (acc > AW'(CAP)) ? CAP : acc[CW-1:0];
					seen_digit_d = 1'b1;
				end
			end else if (rel < declared_length_q) begin
				// payload
				res.payload_valid = 1'b1;
				res.payload_byte = rx_byte;
				res.payload_index = 12'(rel);
			end else begin
				// end marker
				end_marker_ok_d = em_ok;
				if (rel_end >= MARK - 1'b1) begin
					do_open = 1'b1;
					if (em_ok) begin
						res.event_res = EV_DONE;
						res.channel = frame_channel_q;
						res.frame_length = 13'(declared_length_q);
					end else begin
						res.event_res = EV_BAD_END;
					end
				end
			end
		end

		// fresh frame context, active or dropped
		if (do_open) begin
			in_frame_d = open_active;
			frame_channel_d = open_chan;
			byte_count_d = '0;
			prefix_matches_d = 1'b1;
			header_done_d = 1'b0;
			seen_digit_d = 1'b0;
			declared_length_d = '0;
			payload_start_d = '0;
			end_marker_ok_d = 1'b1;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			frame_channel_q <= '0;
			byte_count_q <= '0;
			prefix_matches_q <= 1'b1;
			header_done_q <= 1'b0;
			seen_digit_q <= 1'b0;
			declared_length_q <= '0;
			payload_start_q <= '0;
			end_marker_ok_q <= 1'b1;
		end else if (step) begin
			in_frame_q <= in_frame_d;
			frame_channel_q <= frame_channel_d;
			byte_count_q <= byte_count_d;
			prefix_matches_q <= prefix_matches_d;
			header_done_q <= header_done_d;
			seen_digit_q <= seen_digit_d;
			declared_length_q <= declared_length_d;
			payload_start_q <= payload_start_d;
			end_marker_ok_q <= end_marker_ok_d;
		end
	end

	assign result = res;
endmodule
